// ===== design/box_blur_3x3_inbounds_average_top_assert.svh =====
// Assertion macros for the box blur block.
`ifndef BOX_BLUR_3X3_INBOUNDS_AVERAGE_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_INBOUNDS_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BB3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bb3 assertion failed");

// Next-cycle implication, disabled in reset.
`define BB3_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bb3 assertion failed");

`endif

// ===== design/bb3_pkg.sv =====
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 16'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int RCP_W = 19;
  localparam int RCP_SH = 18;
  localparam int PROD_W = SUM_W + RCP_W;

  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd6:    r = 19'd43691;
      4'd9:    r = 19'd29128;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

// ===== design/bb3_pix_if.sv =====
`timescale 1ns / 1ps
interface bb3_pix_if;
  import bb3_pkg::*;
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
  modport sink (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

// ===== design/bb3_res_if.sv =====
`timescale 1ns / 1ps
interface bb3_res_if;
  import bb3_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            run_last;
  logic            frame_done;
  modport source (output valid, out_red, out_green, out_blue, run_last, frame_done,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, run_last, frame_done,
                output ready);
endinterface

// ===== design/bb3_cfg_if.sv =====
`timescale 1ns / 1ps
interface bb3_cfg_if;
  import bb3_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bb3_ram.sv =====
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/box_blur_3x3_inbounds_average_top.sv =====
`timescale 1ns / 1ps
`include "box_blur_3x3_inbounds_average_top_assert.svh"
// Channel  Port    Dir  Carries
// pixel    in_if   in   opcode, in_red, in_green, in_blue
// result   out_if  out  out_red, out_green, out_blue, run_last, frame_done
// config   cfg_if  in   index (frame_width, frame_height), data
//
// An item with results goes through accept, a line-store read, then a sum step and
// a divide step per result. An item without results returns to idle after the read;
// a drain before frame end is accepted and dropped.
// Sync rst_n clears counters and window, resets config; line stores are not cleared.
// A result waits in the output register while out_if.ready is low; the next
// item is accepted meanwhile, and its first result waits for the register.
module box_blur_3x3_inbounds_average_top #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input logic    clk,
  input logic    rst_n,
  bb3_pix_if.sink   in_if,
  bb3_res_if.source out_if,
  bb3_cfg_if.sink   cfg_if
);
  import bb3_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int WW = (MW_BITS > FW_W) ? MW_BITS : FW_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SUM  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r;

  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [AW-1:0]   col_r;
  logic [FH_W-1:0] row_r;

  logic [PIX_W-1:0] win_r [3][3];
  logic [PIX_W-1:0] pix_r;
  logic [AW-1:0]    idx_r;
  logic             drain_r;
  logic             emit_a_r;
  logic             emit_b_r;
  logic             row0v_r;
  logic             done_r;
  logic [2:0]       colv_r;
  logic             k2_r;

  logic [SUM_W-1:0] sum_r [3];
  logic [CNT_W-1:0] cnt_r;

  logic             out_valid_r;
  logic [CH_W-1:0]  out_ch_r [3];
  logic             run_last_r;
  logic             frame_done_r;

  logic            in_xfer;
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [WW-1:0]   cw;
  logic            drain;
  logic            last_col;
  logic            act;
  logic [2:0]      colv;

  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_addr;
  logic [2*PIX_W-1:0] ram_wdata;
  logic [2*PIX_W-1:0] ram_rdata;

  logic [SUM_W-1:0] sum_nxt [3];
  logic [CNT_W-1:0] cnt_nxt;
  logic [CH_W-1:0]  q_nxt [3];
  logic             out_free;
  logic             run_last_nxt;

  assign in_xfer = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(fw_r) > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
    cw = WW'(col_r);
    drain = (row_r >= h_eff);
    last_col = ((cw + WW'(1)) >= w_eff);
    act = !(in_if.opcode == OP_DRAIN && !drain);
    colv[2] = (cw < w_eff);
    colv[1] = (cw >= WW'(1)) && ((cw - WW'(1)) < w_eff);
    colv[0] = (cw >= WW'(2)) && ((cw - WW'(2)) < w_eff);
  end

  assign ram_re    = (state_r == S_IDLE) && in_xfer && act;
  assign ram_we    = (state_r == S_RD) && !drain_r;
  assign ram_addr  = ram_we ? idx_r : col_r;
  assign ram_wdata = {ram_rdata[PIX_W-1:0], pix_r};

  bb3_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    logic [2:0] rowv;
    logic [2:0] colm;
    logic [1:0] nrows;
    logic [1:0] ncols;
    rowv = {!drain_r, 1'b1, row0v_r};
    colm = k2_r ? (colv_r & 3'b110) : colv_r;
    nrows = 2'(rowv[0]) + 2'(rowv[1]) + 2'(rowv[2]);
    ncols = 2'(colm[0]) + 2'(colm[1]) + 2'(colm[2]);
    cnt_nxt = CNT_W'(nrows) * CNT_W'(ncols);
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (rowv[i] && colm[j]) begin
            sum_nxt[ch] = sum_nxt[ch] + SUM_W'(win_r[i][j][(2-ch)*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  always_comb begin
    logic [SUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    logic [RCP_W-1:0]  rcp;
    rcp = recip(cnt_r);
    for (int ch = 0; ch < 3; ch++) begin
      num = sum_r[ch] + SUM_W'(cnt_r >> 1);
      prod = PROD_W'(num) * PROD_W'(rcp);
      q_nxt[ch] = prod[RCP_SH +: CH_W];
    end
  end

  assign out_free = !out_valid_r || out_if.ready;
  assign run_last_nxt = k2_r || !emit_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fw_r     <= FW_RESET;
      fh_r     <= FH_RESET;
      col_r    <= '0;
      row_r    <= '0;
      out_valid_r <= 1'b0;
      k2_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_if.data[FW_W-1:0];
          CFG_FRAME_HEIGHT: fh_r <= cfg_if.data[FH_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer && act) begin
            state_r  <= S_RD;
            if (last_col) begin
              col_r <= '0;
              row_r <= drain ? '0 : row_r + FH_W'(1);
            end else begin
              col_r <= col_r + AW'(1);
            end
          end
        end
        S_RD: begin
          for (int i = 0; i < 3; i++) begin
            win_r[i][0] <= win_r[i][1];
            win_r[i][1] <= win_r[i][2];
          end
          win_r[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
          win_r[1][2] <= ram_rdata[PIX_W-1:0];
          win_r[2][2] <= pix_r;
          k2_r    <= !emit_a_r;
          state_r <= (emit_a_r || emit_b_r) ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (!k2_r && emit_b_r) begin
              k2_r    <= 1'b1;
              state_r <= S_SUM;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer && act) begin
      pix_r    <= drain ? '0 : {in_if.in_red, in_if.in_green, in_if.in_blue};
      idx_r    <= col_r;
      drain_r  <= drain;
      emit_a_r <= (row_r != '0) && (col_r != '0);
      emit_b_r <= (row_r != '0) && last_col;
      row0v_r  <= (row_r > FH_W'(1));
      done_r   <= drain && last_col;
      colv_r   <= colv;
    end
    if (state_r == S_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= sum_nxt[ch];
      end
      cnt_r <= cnt_nxt;
    end
    if (state_r == S_EMIT && out_free) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_ch_r[ch] <= q_nxt[ch];
      end
      run_last_r   <= run_last_nxt;
      frame_done_r <= done_r && run_last_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_red    = out_ch_r[0];
  assign out_if.out_green  = out_ch_r[1];
  assign out_if.out_blue   = out_ch_r[2];
  assign out_if.run_last   = run_last_r;
  assign out_if.frame_done = frame_done_r;

  `BB3_ASSERT_IMP(a_ram_rw_excl, clk, rst_n, ram_we, !ram_re)
  `BB3_ASSERT_NXT(a_emit_holds, clk, rst_n, state_r == S_EMIT && !out_free, state_r == S_EMIT)
  `BB3_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid_r && frame_done_r, run_last_r)
  `BB3_ASSERT_IMP(a_col_in_range, clk, rst_n, 1'b1, (WW'(col_r) < MAX_W))

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import bb3_pkg::*;

  localparam int LINE_MAX      = MAX_WIDTH_DEF;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 850;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            run_last;
    logic            frame_done;
  } blur_res_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic                  op;
    logic [PIX_W-1:0]      pix;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    logic [1:0]            n_res;
    logic [PIX_W-1:0]      exp_pix;
    logic                  done;
  } step_t;

  localparam int DIR_LEN = 29;
  localparam step_t DIR_STEPS [DIR_LEN] = '{
    '{STEP_CFG,  OP_PIXEL, 24'h000000, CFG_FRAME_WIDTH,  16'd2, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_CFG,  OP_PIXEL, 24'h000000, CFG_FRAME_HEIGHT, 16'd2, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFF00FF, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'h5A5A5A, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFF00FF, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFF0000, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFE0200, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd2, 24'hFF0180, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'h000000, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h0C2238, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd2, 24'hFF0180, 1'b1},
    '{STEP_CFG,  OP_PIXEL, 24'h000000, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_CFG,  OP_PIXEL, 24'h000000, CFG_FRAME_HEIGHT, 16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h00FF00, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'hFFFFFF, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd1, 24'h00FF00, 1'b1},
    '{STEP_ITEM, OP_PIXEL, 24'hAA5501, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'h000000, CFG_FRAME_WIDTH,  16'd0, 1'b1, 2'd1, 24'hAA5501, 1'b1},
    '{STEP_CFG,  OP_PIXEL, 24'h000000, CFG_FRAME_WIDTH,  16'd3, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_CFG,  OP_PIXEL, 24'h000000, CFG_FRAME_HEIGHT, 16'd3, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h000000, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFFFFFF, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h123456, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h800080, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h7F7F7F, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFFFFFF, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h010203, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'hFEDCBA, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_PIXEL, 24'h00FF00, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'h000000, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'hFFFFFF, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{STEP_ITEM, OP_DRAIN, 24'h000000, CFG_FRAME_WIDTH,  16'd0, 1'b0, 2'd0, 24'h000000, 1'b0}
  };

  logic clk;
  logic rst_n;

  bb3_pix_if pix_ch ();
  bb3_res_if res_ch ();
  bb3_cfg_if cfg_ch ();

  box_blur_3x3_inbounds_average_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (pix_ch),
    .out_if(res_ch),
    .cfg_if(cfg_ch)
  );

  // blur predictor state
  logic [PIX_W-1:0] prev_row  [LINE_MAX];
  logic [PIX_W-1:0] prev_row2 [LINE_MAX];
  logic [PIX_W-1:0] nbhd [3][3];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [FW_W-1:0]  cfg_w;
  logic [FH_W-1:0]  cfg_h;
  blur_res_t        blur_out [2];

  blur_res_t blur_due_q [$];
  int        mismatch_cnt;
  int        items_fed;
  int        quiet_cycles;
  int        hold_len;
  bit        send_idle;
  bit        recv_idle;
  bit        pause_due;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int frame_cols();
    int w;
    w = cfg_w;
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int frame_rows();
    return (cfg_h == '0) ? 1 : int'(cfg_h);
  endfunction

  function automatic blur_res_t window_mean(input int k, input int c, input int r, input int w,
                                            input bit drain);
    int unsigned sr, sg, sb, n;
    int y, x;
    logic [PIX_W-1:0] p;
    blur_res_t res;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int i = 0; i < 3; i++) begin
      y = r - 2 + i;
      if (y < 0 || (i == 2 && drain)) continue;
      for (int j = k - 1; j <= k + 1; j++) begin
        if (j < 0 || j > 2) continue;
        x = c - 2 + j;
        if (x < 0 || x >= w) continue;
        p = nbhd[i][j];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
        n++;
      end
    end
    if (n == 0) n = 1;
    res.red        = CH_W'((sr + n / 2) / n);
    res.green      = CH_W'((sg + n / 2) / n);
    res.blue       = CH_W'((sb + n / 2) / n);
    res.run_last   = 1'b0;
    res.frame_done = 1'b0;
    return res;
  endfunction

  // advance the predictor by one transfer; -1 when the block ignores it
  function automatic int blur_step(input logic op, input logic [PIX_W-1:0] pix);
    int w, h, c, r, idx, n;
    bit drain, last_col;
    logic [PIX_W-1:0] p;
    w = frame_cols();
    h = frame_rows();
    c = col_pos;
    r = row_pos;
    idx = c % LINE_MAX;
    drain = r >= h;
    last_col = c + 1 >= w;
    if (op == OP_DRAIN && !drain) return -1;
    p = drain ? '0 : pix;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = prev_row2[idx];
    nbhd[1][2] = prev_row[idx];
    nbhd[2][2] = p;
    if (!drain) begin
      prev_row2[idx] = prev_row[idx];
      prev_row[idx]  = p;
    end
    n = 0;
    if (r >= 1) begin
      if (c >= 1) begin
        blur_out[n] = window_mean(1, c, r, w, drain);
        n++;
      end
      if (last_col) begin
        blur_out[n] = window_mean(2, c, r, w, drain);
        n++;
      end
    end
    if (n > 0) begin
      blur_out[n-1].run_last = 1'b1;
      if (drain && last_col) blur_out[n-1].frame_done = 1'b1;
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = drain ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return n;
  endfunction

  task automatic queue_predicted(input int n);
    for (int k = 0; k < n; k++) blur_due_q.push_back(blur_out[k]);
  endtask

  // drop both request lines, then wait for the last result and let the block settle
  task automatic wait_block_idle();
    pix_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    do @(posedge clk); while (blur_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_block_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_FRAME_WIDTH) cfg_w = value[FW_W-1:0];
    else cfg_h = value[FH_W-1:0];
  endtask

  task automatic feed_item(input logic op, input logic [PIX_W-1:0] pix, output int n_res);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    cfg_ch.valid <= 1'b0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.opcode   <= op;
    pix_ch.in_red   <= pix[23:16];
    pix_ch.in_green <= pix[15:8];
    pix_ch.in_blue  <= pix[7:0];
    do @(posedge clk); while (!pix_ch.ready);
    n_res = blur_step(op, pix);
  endtask

  // frame with stray drains and pixels mixed into the drain row, ended early by cap
  task automatic stream_frame(input int cap);
    int sent, n;
    logic op;
    sent = 0;
    do begin
      if (row_pos >= frame_rows()) op = ($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN;
      else op = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL;
      if (pause_due || $urandom_range(0, 149) == 0) begin
        pause_due = 1'b0;
        wait_block_idle();
      end
      feed_item(op, PIX_W'($urandom), n);
      if (n >= 0) begin
        items_fed++;
        sent++;
        queue_predicted(n);
      end
    end while ((n < 0 || col_pos != 0 || row_pos != 0) && (cap == 0 || sent < cap));
  endtask

  task automatic check_blur_result(input blur_res_t got);
    blur_res_t want;
    logic [CH_W-1:0] ev [5];
    logic [CH_W-1:0] av [5];
    string nm [5];
    if (blur_due_q.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      return;
    end
    want = blur_due_q.pop_front();
    nm = '{"out_red", "out_green", "out_blue", "run_last", "frame_done"};
    ev = '{want.red, want.green, want.blue, CH_W'(want.run_last), CH_W'(want.frame_done)};
    av = '{got.red, got.green, got.blue, CH_W'(got.run_last), CH_W'(got.frame_done)};
    for (int i = 0; i < 5; i++) begin
      if (ev[i] !== av[i]) begin
        mismatch_cnt++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, nm[i], ev[i], av[i]);
      end
    end
  endtask

  // result sink
  initial begin
    int stall;
    blur_res_t got;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = recv_idle ? $urandom_range(0, 8) : 0;
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.red        = res_ch.out_red;
      got.green      = res_ch.out_green;
      got.blue       = res_ch.out_blue;
      got.run_last   = res_ch.run_last;
      got.frame_done = res_ch.frame_done;
      check_blur_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n, fw, fh;
    bit first_phase;
    step_t s;
    blur_res_t r;
    rst_n           <= 1'b0;
    pix_ch.valid    <= 1'b0;
    pix_ch.opcode   <= OP_PIXEL;
    pix_ch.in_red   <= '0;
    pix_ch.in_green <= '0;
    pix_ch.in_blue  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_FRAME_WIDTH;
    cfg_ch.data     <= '0;
    quiet_cycles = 0;
    mismatch_cnt = 0;
    hold_len = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    pause_due = 1'b0;
    foreach (prev_row[i]) begin
      prev_row[i]  = '0;
      prev_row2[i] = '0;
    end
    foreach (nbhd[i, j]) nbhd[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    cfg_w = FW_RESET;
    cfg_h = FH_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_STEPS[i]) begin
      s = DIR_STEPS[i];
      if (s.kind == STEP_CFG) begin
        write_reg(s.idx, s.data);
      end else begin
        feed_item(s.op, s.pix, n);
        if (!s.typed) begin
          queue_predicted(n);
        end else begin
          for (int k = 0; k < s.n_res; k++) begin
            r.red        = s.exp_pix[23:16];
            r.green      = s.exp_pix[15:8];
            r.blue       = s.exp_pix[7:0];
            r.run_last   = (k == s.n_res - 1);
            r.frame_done = (k == s.n_res - 1) && s.done;
            blur_due_q.push_back(r);
          end
        end
      end
    end

    items_fed = 0;
    first_phase = 1'b1;
    while (items_fed < RANDOM_ITEMS) begin
      fw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      fh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      if (first_phase) begin
        fw = 8;
        fh = 6;
      end
      write_reg(CFG_FRAME_WIDTH, {5'($urandom), FW_W'(fw)});
      write_reg(CFG_FRAME_HEIGHT, FH_W'(fh));
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      if (first_phase) begin
        send_idle = 1'b0;
        hold_len = HOLD_CYCLES;
        pause_due = 1'b1;
        first_phase = 1'b0;
      end
      repeat ($urandom_range(1, 3)) stream_frame(0);
    end

    // widest frame, then the tallest setting left unfinished
    write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    stream_frame(0);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(2, 9)));
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    stream_frame(150);

    wait_block_idle();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
